/* src/rmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared types and constants of the randomized multiset table: request and
// response payloads, operation and status codes, and the cell chain records.
// ----------------------------------------------------------------------------
package rmt_pkg;

   localparam int CAPACITY    = 64;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int IDX_WIDTH   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int DATA_WIDTH  = 32;
   localparam int RND_WIDTH   = 32;
   localparam int STEP_WIDTH  = $clog2(RND_WIDTH);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NOP    = 2'd3
   } rmt_opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } rmt_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SWEEP,
      ST_DONE
   } rmt_state_type;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic signed [DATA_WIDTH-1:0] value;
      logic [RND_WIDTH-1:0]         random_word;
   } rmt_req_type;

   typedef struct packed {
      logic                         flag;
      logic signed [DATA_WIDTH-1:0] sampled_value;
      logic [1:0]                   status;
      logic [COUNT_WIDTH-1:0]       element_count;
   } rmt_rsp_type;

   // Values broadcast to every cell; key and count stay steady while a request is in flight.
   typedef struct packed {
      logic [DATA_WIDTH-1:0]  key;
      logic [COUNT_WIDTH-1:0] count;
      logic [IDX_WIDTH-1:0]   sel_idx;
   } rmt_bcast_type;

   // Commit of a request into the cells.
   typedef struct packed {
      logic                  en;
      logic                  at_tail;
      logic [DATA_WIDTH-1:0] data;
   } rmt_write_type;

   // Record that walks the chain one cell per cycle.
   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [DATA_WIDTH-1:0] data;
   } rmt_token_type;

endpackage
`default_nettype wire

/* src/rmt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmt_cell
// One slot of the table. Compares its value against the broadcast key,
// passes the search token on to the next cell and takes part in commits.
// ----------------------------------------------------------------------------
module rmt_cell
   import rmt_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rmt_bcast_type bcast,
   input  wire rmt_write_type wr,
   input  wire rmt_token_type tok_in,
   output rmt_token_type      tok_out
);

   localparam logic [COUNT_WIDTH-1:0] MY_POS = COUNT_WIDTH'(CELL_INDEX);
   localparam logic [IDX_WIDTH-1:0]   MY_IDX = IDX_WIDTH'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  hole_ff;
   logic                  hole_in;
   rmt_token_type         tok_ff;
   rmt_token_type         tok_in_next;
   logic                  hit;
   logic                  wr_here;

   assign hit = (MY_POS < bcast.count) && (value_ff == bcast.key);

   // The first occupied match below which no other match was seen is the hole.
   assign hole_in = tok_in.valid ? (hit & ~tok_in.found) : hole_ff;

   assign wr_here  = wr.en && (wr.at_tail ? (MY_POS == bcast.count) : hole_ff);
   assign value_in = wr_here ? wr.data : value_ff;

   always_comb begin
      tok_in_next.valid = tok_in.valid;
      tok_in_next.found = tok_in.found | hit;
      tok_in_next.data  = (MY_IDX == bcast.sel_idx) ? value_ff : tok_in.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hole_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         hole_ff      <= hole_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.found <= tok_in_next.found;
      tok_ff.data  <= tok_in_next.data;
      value_ff     <= value_in;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

/* src/rmt_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmt_mod
// Restoring remainder unit: one quotient bit per cycle, giving the random
// word modulo the element count.
// ----------------------------------------------------------------------------
module rmt_mod
   import rmt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [RND_WIDTH-1:0]   dividend,
   input  wire logic [COUNT_WIDTH-1:0] divisor,
   output logic                        done,
   output logic [IDX_WIDTH-1:0]        remainder
);

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(RND_WIDTH - 1);

   logic                   busy_ff;
   logic                   busy_in;
   logic                   done_ff;
   logic                   done_in;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [STEP_WIDTH-1:0]  step_in;
   logic [RND_WIDTH-1:0]   shift_ff;
   logic [RND_WIDTH-1:0]   shift_in;
   logic [COUNT_WIDTH-1:0] divisor_ff;
   logic [COUNT_WIDTH-1:0] divisor_in;
   logic [COUNT_WIDTH-1:0] rem_ff;
   logic [COUNT_WIDTH-1:0] rem_in;
   logic [COUNT_WIDTH:0]   trial;
   logic [COUNT_WIDTH:0]   diff;

   assign trial = {rem_ff, shift_ff[RND_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         shift_in   = dividend;
         divisor_in = divisor;
         rem_in     = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[RND_WIDTH-2:0], 1'b0};
         // The partial remainder stays below the divisor, so it fits the count width.
         rem_in   = (trial >= {1'b0, divisor_ff}) ? diff[COUNT_WIDTH-1:0]
                                                  : trial[COUNT_WIDTH-1:0];
         step_in  = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[IDX_WIDTH-1:0];

endmodule
`default_nettype wire

/* src/randomized_multiset_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Insert and remove sweep the cell chain before they answer; sample first runs the
// remainder unit, then sweeps. Full insert, empty sample and no-op skip the sweep.
// The search token walks the cell chain one cell per cycle, and the sample position
// comes from a remainder unit that retires one bit per cycle over the 32-bit word.
// One request is in flight at a time; a finished response waits in its output register.
// Synchronous reset empties the table; slot contents are left as they are.
// ----------------------------------------------------------------------------
// randomized_multiset_table
// Multiset of signed 32-bit values in a dense row of slot cells with a fill
// count: insert, remove one copy (last slot fills the hole), random sample.
// ----------------------------------------------------------------------------
module randomized_multiset_table
   import rmt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire rmt_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rmt_rsp_type      rsp_payload
);

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(CAPACITY);

   rmt_state_type          state_ff;
   rmt_state_type          state_in;
   rmt_opcode_type         op_ff;
   logic [DATA_WIDTH-1:0]  key_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [IDX_WIDTH-1:0]   sel_idx_ff;
   logic                   found_ff;
   logic [DATA_WIDTH-1:0]  data_ff;
   rmt_status_type         status_ff;
   rmt_status_type         status_in;
   logic                   launched_ff;
   logic                   rsp_valid_ff;
   rmt_rsp_type            rsp_ff;
   rmt_rsp_type            rsp_in;

   logic                   req_accept;
   logic                   div_start;
   logic                   div_done;
   logic [IDX_WIDTH-1:0]   div_rem;
   logic                   launch;
   logic                   commit;
   logic                   out_free;
   logic                   is_full;
   logic                   is_empty;
   rmt_opcode_type         req_op;
   rmt_bcast_type          bcast;
   rmt_write_type          wr;
   rmt_token_type          chain_tok [0:CAPACITY];

   assign req_op     = rmt_opcode_type'(req_payload.opcode);
   assign req_accept = req_valid && req_ready;
   assign is_full    = (count_ff == FULL_COUNT);
   assign is_empty   = (count_ff == '0);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_INSERT: state_in = is_full ? ST_DONE : ST_SWEEP;
                  OP_REMOVE: state_in = ST_SWEEP;
                  OP_SAMPLE: state_in = is_empty ? ST_DONE : ST_DIVIDE;
                  OP_NOP:    state_in = ST_DONE;
               endcase
            end
         end
         ST_DIVIDE: if (div_done) state_in = ST_SWEEP;
         ST_SWEEP:  if (chain_tok[CAPACITY].valid) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      div_start = 1'b0;
      if ((state_ff == ST_IDLE) && req_valid && (req_op == OP_SAMPLE) && !is_empty) begin
         div_start = 1'b1;
      end
      launch = (state_ff == ST_SWEEP) && !launched_ff;
      commit = (state_ff == ST_DONE) && out_free;
   end

   always_comb begin
      status_in = STATUS_OK;
      if (req_op == OP_INSERT && is_full) begin
         status_in = STATUS_FULL;
      end else if (req_op == OP_SAMPLE && is_empty) begin
         status_in = STATUS_EMPTY;
      end
   end

   // Commit of the finished request and its response.
   always_comb begin
      wr.en      = 1'b0;
      wr.at_tail = (op_ff == OP_INSERT);
      wr.data    = wr.at_tail ? key_ff : data_ff;
      count_in   = count_ff;
      rsp_in.flag          = 1'b0;
      rsp_in.sampled_value = '0;
      rsp_in.status        = status_ff;
      unique case (op_ff)
         OP_INSERT: begin
            if (status_ff == STATUS_OK) begin
               wr.en       = commit;
               count_in    = count_ff + 1'b1;
               rsp_in.flag = !found_ff;
            end
         end
         OP_REMOVE: begin
            if (found_ff) begin
               wr.en       = commit;
               count_in    = count_ff - 1'b1;
               rsp_in.flag = 1'b1;
            end
         end
         OP_SAMPLE: begin
            if (status_ff == STATUS_OK) begin
               rsp_in.sampled_value = data_ff;
            end
         end
         OP_NOP: begin
         end
      endcase
      rsp_in.element_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= (state_ff == ST_SWEEP);
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         op_ff      <= req_op;
         key_ff     <= req_payload.value;
         status_ff  <= status_in;
         // Remove reads the last occupied slot as it sweeps past.
         sel_idx_ff <= IDX_WIDTH'(count_ff - 1'b1);
      end else if (div_done) begin
         sel_idx_ff <= div_rem;
      end
      if (state_ff == ST_SWEEP && chain_tok[CAPACITY].valid) begin
         found_ff <= chain_tok[CAPACITY].found;
         data_ff  <= chain_tok[CAPACITY].data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign bcast.key     = key_ff;
   assign bcast.count   = count_ff;
   assign bcast.sel_idx = sel_idx_ff;

   assign chain_tok[0].valid = launch;
   assign chain_tok[0].found = 1'b0;
   assign chain_tok[0].data  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      rmt_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .bcast  (bcast),
         .wr     (wr),
         .tok_in (chain_tok[i]),
         .tok_out(chain_tok[i+1])
      );
   end

   rmt_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_payload.random_word),
      .divisor  (count_ff),
      .done     (div_done),
      .remainder(div_rem)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
